@@ hdl/psc_pkg.sv @@
package psc_pkg;

  // derivative term: gain on the change in error, and its dead band / upper cut-off
  localparam int DERIV_SCALE = 10;
  localparam int DERIV_MIN   = 50;
  localparam int DERIV_MAX   = 2400;

  // integrator step factor 0.02 as 1311 / 2^16
  localparam int STEP_NUM    = 1311;
  localparam int STEP_SHIFT  = 16;
  localparam int STEP_W      = 27;

  localparam int INTEG_LIMIT = 80;
  localparam int DRIVE_LIMIT = 127;

  // register map, word index
  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_INTEG = 2'd1;
  localparam logic [1:0] REG_DERIV = 2'd2;

  // state update leaving the datapath
  typedef struct packed {
    logic signed [16:0] error;
    logic signed [7:0]  drive;
  } psc_result_t;

endpackage

@@ hdl/psc_datapath.sv @@
module psc_datapath #(
  parameter int FRACTION_BITS = 8
) (
  input  logic signed [15:0]              setpoint,
  input  logic signed [15:0]              measured,
  input  logic        [15:0]              prop_gain,
  input  logic        [psc_pkg::STEP_W-1:0] integ_step,
  input  logic        [15:0]              deriv_gain,
  input  logic signed [16:0]              previous_error,
  input  logic signed [FRACTION_BITS+7:0] integral_sum,
  output logic signed [FRACTION_BITS+7:0] integral_next,
  output psc_pkg::psc_result_t            result
);
  import psc_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int ISUM_W = F + 8;
  localparam int SUM_W  = 32;

  localparam logic signed [33:0] P_BIAS = (34'sd1 <<< F) - 34'sd1;
  localparam logic signed [44:0] I_BIAS = (45'sd1 <<< STEP_SHIFT) - 45'sd1;
  localparam logic signed [SUM_W-1:0] S_BIAS = (SUM_W'(1) <<< F) - SUM_W'(1);
  localparam logic signed [45:0] I_LIM  = 46'(INTEG_LIMIT) <<< F;

  logic signed [16:0]      err;
  logic signed [17:0]      diff;
  logic signed [21:0]      d_full;
  logic        [21:0]      d_mag;
  logic signed [12:0]      d_gated;
  logic signed [33:0]      p_prod;
  logic signed [33:0]      p_sh;
  logic signed [7:0]       p_clamp;
  logic signed [44:0]      i_prod;
  logic signed [44:0]      i_sh;
  logic signed [45:0]      i_sum;
  logic signed [29:0]      kd_prod;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] total_sh;
  logic signed [7:0]       drive_clamp;

  always_comb begin
    err  = 17'(setpoint) - 17'(measured);
    diff = 18'(err) - 18'(previous_error);

    // times ten as 8x + 2x
    d_full = (22'(diff) <<< 3) + (22'(diff) <<< 1);
    d_mag  = d_full[21] ? 22'(-d_full) : 22'(d_full);
    if (d_mag < 22'(DERIV_MIN) || d_mag > 22'(DERIV_MAX)) begin
      d_gated = '0;
    end else begin
      d_gated = d_full[12:0];
    end

    // proportional, truncated toward zero
    p_prod = err * $signed({1'b0, prop_gain});
    p_sh   = (p_prod + (p_prod[33] ? P_BIAS : 34'sd0)) >>> F;
    if (p_sh > 34'sd127) begin
      p_clamp = 8'(DRIVE_LIMIT);
    end else if (p_sh < -34'sd127) begin
      p_clamp = -8'(DRIVE_LIMIT);
    end else begin
      p_clamp = p_sh[7:0];
    end

    // integrator step and saturation
    i_prod = err * $signed({1'b0, integ_step});
    i_sh   = (i_prod + (i_prod[44] ? I_BIAS : 45'sd0)) >>> STEP_SHIFT;
    i_sum  = 46'(integral_sum) + 46'(i_sh);
    if (i_sum > I_LIM) begin
      integral_next = ISUM_W'(I_LIM);
    end else if (i_sum < -I_LIM) begin
      integral_next = ISUM_W'(-I_LIM);
    end else begin
      integral_next = i_sum[ISUM_W-1:0];
    end

    kd_prod = d_gated * $signed({1'b0, deriv_gain});

    total    = (SUM_W'(p_clamp) <<< F) + SUM_W'(integral_next) + SUM_W'(kd_prod);
    total_sh = (total + (total[SUM_W-1] ? S_BIAS : SUM_W'(0))) >>> F;
    if (total_sh > SUM_W'(DRIVE_LIMIT)) begin
      drive_clamp = 8'(DRIVE_LIMIT);
    end else if (total_sh < -SUM_W'(DRIVE_LIMIT)) begin
      drive_clamp = -8'(DRIVE_LIMIT);
    end else begin
      drive_clamp = total_sh[7:0];
    end

    result.error = err;
    result.drive = drive_clamp;
  end

endmodule

@@ hdl/pid_speed_controller.sv @@
// pid speed loop with saturated drive
//
// input channel: item_valid / item_ready with setpoint and measured (signed
// 16 bit speeds). output channel: drive_valid / drive_ready with drive, a
// signed 8 bit command held within -127..127.
// gains are written over the apb port: prop_gain at 0x0, integ_gain at 0x4,
// deriv_gain at 0x8, unsigned q(16-f).f in pwdata[15:0]; pready is always
// high and reads return the stored gain.
// a word is captured in an input register and goes through one pass of
// arithmetic (three multipliers, integrator add and clamps) into the drive
// register once that register is empty or being emptied; one word per
// cycle is sustained while drive_ready stays high, set by that single register-to-register pass.
// the integrator and previous error update as the word moves into the
// drive register.
// when the receiver stalls, drive holds; one more word can be accepted into
// the input register, after which item_ready drops until drive is taken.
// reset clears the gains, the integrator, the previous error and both
// valid flags.
module pid_speed_controller #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [15:0] setpoint,
  input  logic signed [15:0] measured,
  output logic               drive_valid,
  input  logic               drive_ready,
  output logic signed [7:0]  drive
);
  import psc_pkg::*;

  localparam int ISUM_W = FRACTION_BITS + 8;

  logic [15:0]         prop_gain;
  logic [15:0]         integ_gain;
  logic [15:0]         deriv_gain;
  logic [STEP_W-1:0]   integ_step;

  logic signed [16:0]       previous_error;
  logic signed [ISUM_W-1:0] integral_sum;
  logic signed [ISUM_W-1:0] integral_next;

  // input register
  logic               held;
  logic signed [15:0] setpoint_q;
  logic signed [15:0] measured_q;

  psc_result_t result;
  logic        advance;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // input slot moves on when the drive register is empty or being emptied
  assign advance    = held & (~drive_valid | drive_ready);
  assign item_ready = ~held | ~drive_valid | drive_ready;

  // gains; the 0.02 step is folded into integ_step when integ_gain is written
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      integ_step <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PROP:  prop_gain <= pwdata[15:0];
        REG_INTEG: begin
          integ_gain <= pwdata[15:0];
          integ_step <= STEP_W'(pwdata[15:0]) * STEP_W'(STEP_NUM);
        end
        REG_DERIV: deriv_gain <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PROP:  prdata = {16'b0, prop_gain};
      REG_INTEG: prdata = {16'b0, integ_gain};
      REG_DERIV: prdata = {16'b0, deriv_gain};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_valid && item_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      setpoint_q <= setpoint;
      measured_q <= measured;
    end
  end

  psc_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .setpoint       (setpoint_q),
    .measured       (measured_q),
    .prop_gain      (prop_gain),
    .integ_step     (integ_step),
    .deriv_gain     (deriv_gain),
    .previous_error (previous_error),
    .integral_sum   (integral_sum),
    .integral_next  (integral_next),
    .result         (result)
  );

  // loop state commits with the word entering the drive register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (advance) begin
      previous_error <= result.error;
      integral_sum   <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= result.drive;
    end
  end

  // integrator stays inside its limit
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= (ISUM_W'(INTEG_LIMIT) <<< FRACTION_BITS)) &&
    (integral_sum >= -(ISUM_W'(INTEG_LIMIT) <<< FRACTION_BITS)))
    else $error("integrator out of range");

  // the clamp never lets the most negative code through
  a_drive_sym: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive != -8'sd128))
    else $error("drive reached -128");

  // a held word that cannot move stays held
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (held && !advance) |=> held)
    else $error("input word lost");

  // a word moving on always lands in the drive register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> drive_valid)
    else $error("result not delivered");

  // previous error only changes when a word moves on
  a_prev_err: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(previous_error))
    else $error("previous error changed without a word");

endmodule
